[rtl/spt_pkg.sv]
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types for the session park table: slot layout and the command and
// status words passed between controller and datapath.
// ----------------------------------------------------------------------------
package spt_pkg;

   localparam int TOKEN_W = 64;
   localparam int ADDR_W  = 32;
   localparam int ID_W    = 31;

   // request kind codes
   localparam logic KIND_PARK = 1'b0;
   localparam logic KIND_WAKE = 1'b1;

   typedef struct packed {
      logic [TOKEN_W-1:0] token;
      logic [ADDR_W-1:0]  addr;
      logic [ID_W-1:0]    user;
      logic [ID_W-1:0]    dir;
   } slot_type;

   // controller to datapath
   typedef struct packed {
      logic capture;    // latch request word, clear result
      logic park;       // write at tail, update ring pointers
      logic scan_clear; // restart scan at slot zero
      logic scan_run;   // read next slot, compare the previous one
      logic hit_latch;  // take ids of the matched slot into the result
      logic head_rd;    // read the oldest slot
      logic move_wr;    // copy oldest slot into matched slot, pop head
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;        // occupied slot matches token and address
      logic scan_end;   // last slot compared without a match
   } ctrl_status_type;

endpackage

[rtl/spt_dpath.sv]
// ----------------------------------------------------------------------------
// spt_dpath
// Slot memory, ring pointers, request and result registers, and the
// one-slot-per-cycle compare used by the wake scan.
// ----------------------------------------------------------------------------
module spt_dpath
   import spt_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output ctrl_status_type    status,
   input  logic [TOKEN_W-1:0] req_key_token,
   input  logic [ADDR_W-1:0]  req_client_addr,
   input  logic [ID_W-1:0]    req_user_id,
   input  logic [ID_W-1:0]    req_dir_id,
   output logic               rsp_found,
   output logic               rsp_evicted,
   output logic [ID_W-1:0]    rsp_user_out,
   output logic [ID_W-1:0]    rsp_dir_out
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   slot_type           mem [SLOTS];
   slot_type           rd_ff;
   slot_type           key_ff;
   logic [IDX_W-1:0]   head_ff, tail_ff, scan_ff, cmp_idx_ff, match_idx_ff;
   logic               full_ff, rd_valid_ff;
   logic               found_ff, evicted_ff;
   logic [ID_W-1:0]    user_ff, dir_ff;

   logic [IDX_W-1:0]   head_in, tail_in, rd_addr;
   logic               full_in, occupied, key_match;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      if (idx == LAST_IDX) begin
         return '0;
      end
      return idx + 1'b1;
   endfunction

   // slot under compare lies between head and tail in ring order
   always_comb begin
      if (full_ff) begin
         occupied = 1'b1;
      end else if (head_ff <= tail_ff) begin
         occupied = (cmp_idx_ff >= head_ff) && (cmp_idx_ff < tail_ff);
      end else begin
         occupied = (cmp_idx_ff >= head_ff) || (cmp_idx_ff < tail_ff);
      end
   end

   assign key_match = (rd_ff.token == key_ff.token) && (rd_ff.addr == key_ff.addr);
   assign status.hit      = rd_valid_ff && occupied && key_match;
   assign status.scan_end = rd_valid_ff && (cmp_idx_ff == LAST_IDX) && !status.hit;

   assign rd_addr = cmd.head_rd ? head_ff : scan_ff;

   // ring pointer updates
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      full_in = full_ff;
      if (cmd.park) begin
         if (full_ff) begin
            head_in = ring_next(head_ff);
         end
         tail_in = ring_next(tail_ff);
         full_in = (ring_next(tail_ff) == head_in);
      end else if (cmd.move_wr) begin
         head_in = ring_next(head_ff);
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         full_ff     <= 1'b0;
         rd_valid_ff <= 1'b0;
         scan_ff     <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         full_ff <= full_in;
         if (cmd.scan_clear) begin
            scan_ff     <= '0;
            rd_valid_ff <= 1'b0;
         end else if (cmd.scan_run) begin
            scan_ff     <= ring_next(scan_ff);
            rd_valid_ff <= 1'b1;
         end else if (cmd.hit_latch || cmd.head_rd) begin
            rd_valid_ff <= 1'b0;
         end
      end
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.park) begin
         mem[tail_ff] <= key_ff;
      end else if (cmd.move_wr) begin
         mem[match_idx_ff] <= rd_ff;
      end
      if (cmd.scan_run || cmd.head_rd) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // request word, compare index and result word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff.token <= req_key_token;
         key_ff.addr  <= req_client_addr;
         key_ff.user  <= req_user_id;
         key_ff.dir   <= req_dir_id;
         found_ff     <= 1'b0;
         evicted_ff   <= 1'b0;
         user_ff      <= '0;
         dir_ff       <= '0;
      end
      if (cmd.scan_run) begin
         cmp_idx_ff <= scan_ff;
      end
      if (cmd.park) begin
         evicted_ff <= full_ff;
      end
      if (cmd.hit_latch) begin
         found_ff     <= 1'b1;
         user_ff      <= rd_ff.user;
         dir_ff       <= rd_ff.dir;
         match_idx_ff <= cmp_idx_ff;
      end
   end

   assign rsp_found    = found_ff;
   assign rsp_evicted  = evicted_ff;
   assign rsp_user_out = user_ff;
   assign rsp_dir_out  = dir_ff;

endmodule

[rtl/spt_ctrl.sv]
// ----------------------------------------------------------------------------
// spt_ctrl
// Sequencer for park and wake: issues datapath commands, raises busy and
// the one-cycle result strobe.
// ----------------------------------------------------------------------------
module spt_ctrl
   import spt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            req_kind,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd,
   output logic            busy,
   output logic            rsp_strobe
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PARK,
      ST_SCAN,
      ST_HEAD_RD,
      ST_MOVE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      busy_in   = busy_ff;
      strobe_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture    = 1'b1;
               cmd.scan_clear = 1'b1;
               busy_in        = 1'b1;
               state_in       = (req_kind == KIND_PARK) ? ST_PARK : ST_SCAN;
            end
         end
         ST_PARK: begin
            cmd.park  = 1'b1;
            busy_in   = 1'b0;
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SCAN: begin
            if (status.hit) begin
               cmd.hit_latch = 1'b1;
               state_in      = ST_HEAD_RD;
            end else if (status.scan_end) begin
               busy_in   = 1'b0;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         ST_HEAD_RD: begin
            cmd.head_rd = 1'b1;
            state_in    = ST_MOVE;
         end
         ST_MOVE: begin
            cmd.move_wr = 1'b1;
            busy_in     = 1'b0;
            strobe_in   = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            busy_in  = 1'b0;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

[rtl/session_park_table.sv]
// ----------------------------------------------------------------------------
// session_park_table
// Ring-ordered table of parked sessions with eviction of the oldest entry
// and keyed wake lookup.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low; busy then stays
// high until the result, which is flagged on the rsp_ ports by rsp_strobe for
// one cycle and cannot be held off. A park holds busy through the park state
// alone, and its result appears the cycle after. A wake walks the slots in
// ascending order through the single registered read port of the slot memory,
// one slot per cycle: a miss ends once the last slot is compared, a hit goes
// on after the scan to a read of the oldest entry and its copy into the freed
// slot. A new request may be started in the cycle the result is shown.
module session_park_table
   import spt_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_kind,
   input  logic [TOKEN_W-1:0] req_key_token,
   input  logic [ADDR_W-1:0]  req_client_addr,
   input  logic [ID_W-1:0]    req_user_id,
   input  logic [ID_W-1:0]    req_dir_id,
   output logic               rsp_strobe,
   output logic               rsp_found,
   output logic               rsp_evicted,
   output logic [ID_W-1:0]    rsp_user_out,
   output logic [ID_W-1:0]    rsp_dir_out
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   spt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_kind   (req_kind),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   spt_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_key_token   (req_key_token),
      .req_client_addr (req_client_addr),
      .req_user_id     (req_user_id),
      .req_dir_id      (req_dir_id),
      .rsp_found       (rsp_found),
      .rsp_evicted     (rsp_evicted),
      .rsp_user_out    (rsp_user_out),
      .rsp_dir_out     (rsp_dir_out)
   );

   // a result only closes a request that was in flight
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a request in flight");

   // an accepted word always holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // park write and move write share the memory write port
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.park && cmd.move_wr))
      else $error("two slot writes in one cycle");

   // a word is either a park or a wake, never both outcomes
   a_found_evicted: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_found && rsp_evicted))
      else $error("result flags both hit and eviction");

endmodule
